[rtl/core/ffpa_pkg.sv]
// Package with the shared constants, types and control structures of the page allocator.
package ffpa_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_AW   = $clog2(MAX_PAGES);
    localparam int CNT_W     = PAGE_AW + 1;

    localparam logic [1:0] FLAG_TAKEN = 2'b01;
    localparam logic [1:0] FLAG_LAST  = 2'b10;
    localparam logic [1:0] FLAG_NONE  = 2'b00;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    clr_step;
        logic    load_req;
        logic    scan_start;
        logic    scan_run;
        logic    free_clear;
        logic    mark_start;
        logic    mark_run;
        logic    res_load;
        t_status res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic pre_bad;
        logic pre_nospace;
        logic dvld;
        logic hit;
        logic data_taken;
        logic data_last;
        logic is_start;
        logic at_end;
        logic mark_done;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/ffpa_datapath.sv]
// Datapath of the page allocator: flag memory, scan pointers, counters and result register.
module ffpa_datapath import ffpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CNT_W-1:0]   i_cfg_pages_in_use,
    input  logic               i_req_type,
    input  logic [CNT_W-1:0]   i_page_count,
    input  logic [PAGE_AW-1:0] i_page_index,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [PAGE_AW-1:0] o_first_page,
    output logic [CNT_W-1:0]   o_pages_freed,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts
);

    logic [1:0]         r_mem [MAX_PAGES];
    logic [1:0]         r_rdata;
    logic [CNT_W-1:0]   r_pages_in_use;
    logic [PAGE_AW-1:0] r_clr_ptr;
    logic               r_ovld;
    logic               r_dvld;
    logic               r_req_type;
    logic [CNT_W-1:0]   r_count;
    logic [PAGE_AW-1:0] r_index;
    logic [CNT_W-1:0]   r_n;
    logic [PAGE_AW-1:0] r_raddr;
    logic [PAGE_AW-1:0] r_didx;
    logic [CNT_W-1:0]   r_run;
    logic [CNT_W-1:0]   r_freed;
    logic [PAGE_AW-1:0] r_wptr;
    logic [PAGE_AW-1:0] r_end;
    logic [PAGE_AW-1:0] r_first;
    logic [1:0]         r_status;
    logic [PAGE_AW-1:0] r_first_out;
    logic [CNT_W-1:0]   r_freed_out;

    logic               mem_we;
    logic [PAGE_AW-1:0] mem_waddr;
    logic [1:0]         mem_wdata;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   first_calc;
    logic [CNT_W-1:0]   n_limit;

    assign run_inc    = r_run + CNT_W'(1);
    assign first_calc = {1'b0, r_didx} + CNT_W'(1) - r_count;
    assign n_limit    = (r_pages_in_use > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : r_pages_in_use;

    always_comb begin
        o_sts.clr_done    = (r_clr_ptr == PAGE_AW'(MAX_PAGES - 1));
        o_sts.is_free     = r_req_type;
        o_sts.pre_bad     = r_req_type ? ({1'b0, r_index} >= r_n) : (r_count == '0);
        o_sts.pre_nospace = !r_req_type && (r_count > r_n);
        o_sts.dvld        = r_dvld;
        o_sts.data_taken  = (r_rdata & FLAG_TAKEN) != FLAG_NONE;
        o_sts.data_last   = (r_rdata & FLAG_LAST) != FLAG_NONE;
        o_sts.hit         = !o_sts.data_taken && (run_inc == r_count);
        o_sts.is_start    = (r_didx == r_index);
        o_sts.at_end      = ({1'b0, r_didx} + CNT_W'(1)) == r_n;
        o_sts.mark_done   = (r_wptr == r_end);
        o_sts.out_free    = !r_ovld || i_out_ready;
    end

    always_comb begin
        mem_we    = i_cmd.clr_step || i_cmd.free_clear || i_cmd.mark_run;
        mem_waddr = r_wptr;
        mem_wdata = FLAG_NONE;
        if (i_cmd.clr_step) begin
            mem_waddr = r_clr_ptr;
        end else if (i_cmd.free_clear) begin
            mem_waddr = r_didx;
        end else if (i_cmd.mark_run) begin
            mem_wdata = o_sts.mark_done ? (FLAG_TAKEN | FLAG_LAST) : FLAG_TAKEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= CNT_W'(MAX_PAGES);
            r_clr_ptr      <= '0;
            r_ovld         <= 1'b0;
            r_dvld         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pages_in_use <= i_cfg_pages_in_use;
            end
            if (i_cmd.clr_step) begin
                r_clr_ptr <= r_clr_ptr + PAGE_AW'(1);
            end
            if (i_cmd.res_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_dvld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_dvld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_count    <= i_page_count;
            r_index    <= i_page_index;
            r_n        <= n_limit;
        end
        if (i_cmd.scan_start) begin
            r_raddr <= r_req_type ? r_index : '0;
            r_run   <= '0;
            r_freed <= '0;
        end else if (i_cmd.scan_run) begin
            r_raddr <= r_raddr + PAGE_AW'(1);
            r_didx  <= r_raddr;
            if (r_dvld && !r_req_type) begin
                r_run <= o_sts.data_taken ? '0 : run_inc;
            end
        end
        if (i_cmd.free_clear) begin
            r_freed <= r_freed + CNT_W'(1);
        end
        if (i_cmd.mark_start) begin
            r_wptr  <= first_calc[PAGE_AW-1:0];
            r_first <= first_calc[PAGE_AW-1:0];
            r_end   <= r_didx;
        end else if (i_cmd.mark_run) begin
            r_wptr <= r_wptr + PAGE_AW'(1);
        end
        if (i_cmd.res_load) begin
            r_status    <= i_cmd.res_code;
            r_first_out <= (i_cmd.res_code == ST_OK && !r_req_type) ? r_first : '0;
            r_freed_out <= (i_cmd.res_code == ST_OK && r_req_type) ? r_freed : '0;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_status      = r_status;
    assign o_first_page  = r_first_out;
    assign o_pages_freed = r_freed_out;

endmodule

[rtl/core/ffpa_ctrl.sv]
// Controller state machine of the page allocator.
module ffpa_ctrl import ffpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.res_code = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.pre_bad) begin
                    n_code  = ST_BAD;
                    n_state = S_RESP;
                end else if (i_sts.pre_nospace) begin
                    n_code  = ST_NO_SPACE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.dvld) begin
                    if (i_sts.is_free) begin
                        if (i_sts.is_start && !i_sts.data_taken) begin
                            n_code  = ST_BAD;
                            n_state = S_RESP;
                        end else begin
                            o_cmd.free_clear = 1'b1;
                            if (i_sts.data_last || i_sts.at_end) begin
                                n_code  = ST_OK;
                                n_state = S_RESP;
                            end
                        end
                    end else if (i_sts.hit) begin
                        o_cmd.mark_start = 1'b1;
                        n_state          = S_MARK;
                    end else if (i_sts.at_end) begin
                        n_code  = ST_NO_SPACE;
                        n_state = S_RESP;
                    end
                end
            end
            S_MARK: begin
                o_cmd.mark_run = 1'b1;
                if (i_sts.mark_done) begin
                    n_code  = ST_OK;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/first_fit_page_allocator.sv]
// Top level of the first-fit contiguous page allocator.
// After reset the block clears every entry of its page flag memory and takes no request
// until that pass is done; configuration beats are taken at any time. Requests are handled one
// at a time and the page flags are visited one page per cycle through one read port and one
// write port. An allocate scans up to the end of the first free run that fits and then marks
// that run; a free clears pages from its index up to the last page of its block. A new request
// is accepted while the previous result still waits in the output register.
module first_fit_page_allocator import ffpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_pages_in_use,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [CNT_W-1:0]   i_page_count,
    input  logic [PAGE_AW-1:0] i_page_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [PAGE_AW-1:0] o_first_page,
    output logic [CNT_W-1:0]   o_pages_freed
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ffpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffpa_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_pages_in_use (i_cfg_pages_in_use),
        .i_req_type         (i_req_type),
        .i_page_count       (i_page_count),
        .i_page_index       (i_page_index),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_first_page       (o_first_page),
        .o_pages_freed      (o_pages_freed),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

endmodule

[rtl/core/ffpa_checker.sv]
// Port-level assertions for the page allocator and the bind that attaches them.
module ffpa_checker import ffpa_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_status,
    input logic [PAGE_AW-1:0] o_first_page,
    input logic [CNT_W-1:0]   o_pages_freed
);

    // A result beat that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_first_page) && $stable(o_pages_freed))
        else $error("result beat changed before it was taken");

    // Only one request is in work at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // A failed request carries no page information.
    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_first_page == '0 && o_pages_freed == '0)
        else $error("failed request returned page fields");

    // A free never clears more pages than exist, and an allocate never reports freed pages.
    a_freed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pages_freed <= CNT_W'(MAX_PAGES)
            && (o_pages_freed == '0 || o_first_page == '0))
        else $error("freed page count out of range");

    // Status never shows the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_NO_SPACE || o_status == ST_BAD)
        else $error("unused status code on the result port");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (.*);

[tb/first_fit_page_allocator_tb.sv]
// Self-checking testbench for the first-fit page allocator, with directed and random requests.
`timescale 1ns / 100ps

module first_fit_page_allocator_tb import ffpa_pkg::*; ;

    localparam logic REQ_ALLOC         = 1'b0;
    localparam logic REQ_FREE          = 1'b1;
    localparam int   LONG_STALL_CYCLES = 300;
    localparam int   SETTLE_CYCLES     = 20;
    localparam int   REPORT_LIMIT      = 10;

    typedef struct {
        t_status              status;
        logic [PAGE_AW-1:0]   first_page;
        logic [CNT_W-1:0]     pages_freed;
    } t_alloc_reply;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_valid        = 1'b0;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_pages_in_use = '0;
    logic               i_in_valid         = 1'b0;
    logic               o_in_ready;
    logic               i_req_type         = REQ_ALLOC;
    logic [CNT_W-1:0]   i_page_count       = '0;
    logic [PAGE_AW-1:0] i_page_index       = '0;
    logic               o_out_valid;
    logic               i_out_ready        = 1'b0;
    logic [1:0]         o_status;
    logic [PAGE_AW-1:0] o_first_page;
    logic [CNT_W-1:0]   o_pages_freed;

    logic [1:0]         flag_mirror [MAX_PAGES];
    logic [CNT_W-1:0]   pages_managed = CNT_W'(1024);
    t_alloc_reply       awaited_replies [$];
    t_alloc_reply       head_reply;
    int                 mismatch_count = 0;
    int                 idle_limit     = 5;
    logic               out_held       = 1'b0;
    event               hold_start;

    first_fit_page_allocator DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_pages_in_use (i_cfg_pages_in_use),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_page_count       (i_page_count),
        .i_page_index       (i_page_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_first_page       (o_first_page),
        .o_pages_freed      (o_pages_freed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        foreach (flag_mirror[p]) flag_mirror[p] = FLAG_NONE;
    end

    function automatic int managed_span();
        return (pages_managed < MAX_PAGES) ? int'(pages_managed) : MAX_PAGES;
    endfunction

    function automatic bit mirror_taken(int p);
        return (flag_mirror[p] & FLAG_TAKEN) != FLAG_NONE;
    endfunction

    function automatic bit mirror_last(int p);
        return (flag_mirror[p] & FLAG_LAST) != FLAG_NONE;
    endfunction

    function automatic t_alloc_reply compute_reply(logic kind, logic [CNT_W-1:0] count,
                                                   logic [PAGE_AW-1:0] index);
        t_alloc_reply r;
        int n;
        int run;
        int first;
        bit was_last;
        r.status      = ST_OK;
        r.first_page  = '0;
        r.pages_freed = '0;
        n = managed_span();
        if (kind == REQ_ALLOC) begin
            if (count == 0) begin
                r.status = ST_BAD;
            end else if (int'(count) > n) begin
                r.status = ST_NO_SPACE;
            end else begin
                r.status = ST_NO_SPACE;
                run = 0;
                for (int i = 0; i < n; i++) begin
                    run = mirror_taken(i) ? 0 : run + 1;
                    if (run == int'(count)) begin
                        first = i + 1 - int'(count);
                        for (int k = first; k < i; k++) flag_mirror[k] = FLAG_TAKEN;
                        flag_mirror[i] = FLAG_TAKEN | FLAG_LAST;
                        r.status     = ST_OK;
                        r.first_page = first[PAGE_AW-1:0];
                        break;
                    end
                end
            end
        end else begin
            if (int'(index) >= n || !mirror_taken(int'(index))) begin
                r.status = ST_BAD;
            end else begin
                for (int i = int'(index); i < n; i++) begin
                    was_last = mirror_last(i);
                    flag_mirror[i] = FLAG_NONE;
                    r.pages_freed++;
                    if (was_last) break;
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endtask

    task automatic send_request(input logic kind, input logic [CNT_W-1:0] count,
                                input logic [PAGE_AW-1:0] index);
        int gap;
        gap = $urandom_range(idle_limit, 0);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_req_type   = kind;
        i_page_count = count;
        i_page_index = index;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        awaited_replies.push_back(compute_reply(kind, count, index));
    endtask

    task automatic settle_requests();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_pages_in_use(input logic [CNT_W-1:0] value);
        settle_requests();
        @(negedge i_clk);
        i_cfg_valid        = 1'b1;
        i_cfg_pages_in_use = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pages_managed = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly allocations of modest size and frees of real block starts; the rest is noise.
    task automatic issue_random_request();
        int n;
        int pick;
        int start;
        int p;
        logic kind;
        logic [CNT_W-1:0] count;
        logic [PAGE_AW-1:0] index;
        n     = managed_span();
        pick  = $urandom_range(99, 0);
        kind  = 1'($urandom_range(1, 0));
        count = CNT_W'($urandom_range(2047, 0));
        index = PAGE_AW'($urandom_range(MAX_PAGES - 1, 0));
        if (n > 0 && pick < 45) begin
            kind = REQ_ALLOC;
            if ($urandom_range(9, 0) == 0) count = CNT_W'($urandom_range(n, 1));
            else count = CNT_W'($urandom_range((n >= 8) ? n / 4 : 1, 1));
        end else if (n > 0 && pick < 88) begin
            kind  = REQ_FREE;
            start = $urandom_range(n - 1, 0);
            for (int k = 0; k < n; k++) begin
                p = (start + k) % n;
                if (mirror_taken(p) && (p == 0 || !mirror_taken(p - 1) || mirror_last(p - 1)))
                        begin
                    index = PAGE_AW'(p);
                    break;
                end
            end
        end else if (n > 0 && pick < 93) begin
            kind  = REQ_FREE;
            index = PAGE_AW'($urandom_range(n - 1, 0));
        end
        send_request(kind, count, index);
    endtask

    task automatic run_random_phase(input int pages, input int items, input int gap_limit);
        write_pages_in_use(CNT_W'(pages));
        idle_limit = gap_limit;
        repeat (items) issue_random_request();
        idle_limit = 5;
    endtask

    task automatic test_alloc_free_basics();
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 2047, 1023);
        send_request(REQ_FREE, 0, 5);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_ALLOC, 3, 0);
        send_request(REQ_FREE, 0, 2);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 0, 1);
        send_request(REQ_ALLOC, 1024, 0);
        send_request(REQ_FREE, 2047, 1023);
        send_request(REQ_FREE, 0, 0);
    endtask

    task automatic test_register_extremes();
        write_pages_in_use(16);
        send_request(REQ_ALLOC, 10, 0);
        write_pages_in_use(8);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 3);
        write_pages_in_use(16);
        send_request(REQ_FREE, 0, 8);
        send_request(REQ_FREE, 0, 0);
        write_pages_in_use(0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_FREE, 0, 0);
        write_pages_in_use(2047);
        send_request(REQ_ALLOC, 1024, 0);
        send_request(REQ_FREE, 0, 0);
        write_pages_in_use(1);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 0, 0);
    endtask

    task automatic test_random_traffic();
        run_random_phase(64, 260, 5);
        run_random_phase(16, 160, 5);
        run_random_phase(200, 200, 0);
        run_random_phase(1024, 100, 5);
        run_random_phase(2047, 50, 3);
        run_random_phase(3, 100, 5);
        run_random_phase(1000, 100, 5);
        run_random_phase(40, 150, 5);
    endtask

    task automatic test_output_stall();
        write_pages_in_use(32);
        idle_limit = 0;
        -> hold_start;
        repeat (60) issue_random_request();
        idle_limit = 5;
    endtask

    initial begin : long_hold
        forever begin
            @(hold_start);
            out_held = 1'b1;
            repeat (LONG_STALL_CYCLES) @(negedge i_clk);
            out_held = 1'b0;
        end
    end

    initial begin : reply_sink
        int wait_cycles;
        forever begin
            wait_cycles = $urandom_range(idle_limit, 0);
            repeat (wait_cycles) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
            end
            do begin
                @(negedge i_clk);
                i_out_ready = !out_held;
                @(posedge i_clk);
            end while (!(i_out_ready && o_out_valid));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_replies.size() == 0) begin
                note_mismatch($sformatf("unexpected reply status %0d first_page %0d freed %0d",
                                        o_status, o_first_page, o_pages_freed));
            end else begin
                head_reply = awaited_replies.pop_front();
                if (o_status !== head_reply.status || o_first_page !== head_reply.first_page
                        || o_pages_freed !== head_reply.pages_freed) begin
                    note_mismatch($sformatf(
                        "status exp %0d got %0d, first_page exp %0d got %0d, freed exp %0d got %0d",
                        head_reply.status, o_status, head_reply.first_page, o_first_page,
                        head_reply.pages_freed, o_pages_freed));
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_alloc_free_basics();
        test_register_extremes();
        test_random_traffic();
        test_output_stall();
        settle_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0) begin
            $display("** first_fit_page_allocator: PASSED **");
        end else begin
            $display("** first_fit_page_allocator: FAILED **");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("** first_fit_page_allocator: FAILED **");
        $finish;
    end

endmodule
